// ===== rtl/core/brb_pkg.sv =====
// brb_pkg: shared types and operation codes for the byte ring buffer fifo
`timescale 1ns / 1ps

package brb_pkg;

  // field widths fixed by the stream formats
  localparam int KIND_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 9;
  localparam int RPOS_W  = 8;

  // operation codes carried in the input kind field
  localparam logic [KIND_W-1:0] KIND_PUT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FORCE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GET   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  // status of one operation, handed from the core to the output stage
  typedef struct packed {
    logic              accepted;
    logic              get_ok;
    logic              dropped;
    logic [CNT_W-1:0]  data_count;
    logic [CNT_W-1:0]  space_count;
    logic [CNT_W-1:0]  contiguous_count;
    logic [RPOS_W-1:0] read_position;
  } brb_status_t;

endpackage

// ===== rtl/core/byte_ring_buffer_fifo.sv =====
// byte_ring_buffer_fifo: top level with stream handshake and output register
`timescale 1ns / 1ps

// Byte FIFO driven by a stream of operations (put, forced put, get, status,
// clear), each beat returning one status beat. One operation is accepted in
// every clock cycle unless a stall on m_tready backs up to the input. The
// status register and the store's registered read port capture each result,
// then the output register, which lets a new beat in while a finished result waits on m_tready.
// A write on the cfg port sets the ring size (0 reads as 1, values above the
// store size are clamped) and empties the FIFO; it takes effect at once.
module byte_ring_buffer_fifo #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] write_byte
  input  logic [2:0]  s_tuser,   // [2:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] accepted, [8:1] read_byte, [9] dropped_oldest, [18:10] data_count,
  // [27:19] space_count, [36:28] contiguous_count, [44:37] read_position,
  // [47:45] zero
  output logic [47:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);
  import brb_pkg::*;

  brb_status_t       status;
  logic [BYTE_W-1:0] rd_byte;
  logic              s1_valid;
  logic              out_free, s1_move, in_fire, cfg_fire;
  logic [BYTE_W-1:0] read_byte;

  // handshake
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !m_tvalid || m_tready;
  assign s1_move   = s1_valid && out_free;
  assign s_tready  = !s1_valid || out_free;
  assign in_fire   = s_tvalid && s_tready;

  brb_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_fire),
    .cfg_value (cfg_data),
    .op_fire   (in_fire),
    .kind      (s_tuser),
    .write_byte(s_tdata),
    .status    (status),
    .rd_byte   (rd_byte)
  );

  // valid flags for the status stage and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // only a successful get reports the store byte
  assign read_byte = status.get_ok ? rd_byte : '0;

  // output beat
  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= {3'b000, status.read_position, status.contiguous_count,
                  status.space_count, status.data_count, status.dropped,
                  read_byte, status.accepted};
    end
  end

endmodule

// ===== rtl/core/brb_ram.sv =====
// brb_ram: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/brb_core.sv =====
// brb_core: ring indices with mirror bits, byte store and per-operation status register
`timescale 1ns / 1ps

module brb_core #(
  parameter int DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [brb_pkg::CNT_W-1:0]    cfg_value,
  input  logic                         op_fire,
  input  logic [brb_pkg::KIND_W-1:0]   kind,
  input  logic [brb_pkg::BYTE_W-1:0]   write_byte,
  output brb_pkg::brb_status_t         status,
  output logic [brb_pkg::BYTE_W-1:0]   rd_byte
);
  import brb_pkg::*;

  // largest usable ring: bounded by the store and by the 9 bit capacity register
  localparam int CAP_MAX   = (DEPTH < 511) ? DEPTH : 511;
  localparam int CAP_RST   = (DEPTH < 256) ? DEPTH : 256;
  localparam int PW        = $clog2(CAP_MAX);

  logic [CNT_W-1:0] capacity;
  logic [PW-1:0]    read_pos, write_pos;
  logic             read_wrap, write_wrap;

  logic [PW-1:0]    read_pos_next, write_pos_next;
  logic             read_wrap_next, write_wrap_next;
  logic             wr_en, acc, get_ok, dropped;
  logic [CNT_W-1:0] fill_pre, fill_post, cap_next;
  logic             full, empty;

  // bytes held for a given index pair
  function automatic logic [CNT_W-1:0] fill_of(
    input logic [PW-1:0] rp, input logic rw,
    input logic [PW-1:0] wp, input logic ww, input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] r9, w9;
    r9 = CNT_W'(rp);
    w9 = CNT_W'(wp);
    if (rw == ww && r9 <= w9) begin
      fill_of = w9 - r9;
    end else begin
      fill_of = cap - r9 + w9;
    end
  endfunction

  // readable bytes from the read index up to the end of the ring
  function automatic logic [CNT_W-1:0] run_of(
    input logic [PW-1:0] rp, input logic rw,
    input logic [PW-1:0] wp, input logic ww, input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] r9, w9;
    r9 = CNT_W'(rp);
    w9 = CNT_W'(wp);
    if (r9 <= w9 && rw == ww) begin
      run_of = w9 - r9;
    end else begin
      run_of = cap - r9;
    end
  endfunction

  // advance an index, wrapping to zero and flipping the mirror bit at the ring end
  function automatic logic [PW:0] step_of(
    input logic [PW-1:0] pos, input logic wrap, input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] inc;
    inc = (CNT_W+1)'(pos) + 1'b1;
    if (inc >= {1'b0, cap}) begin
      step_of = {~wrap, {PW{1'b0}}};
    end else begin
      step_of = {wrap, inc[PW-1:0]};
    end
  endfunction

  // status before the operation
  assign fill_pre = fill_of(read_pos, read_wrap, write_pos, write_wrap, capacity);
  assign full     = (capacity - fill_pre) == '0;
  assign empty    = fill_pre == '0;

  // operation decode and index update
  always_comb begin
    read_pos_next   = read_pos;
    read_wrap_next  = read_wrap;
    write_pos_next  = write_pos;
    write_wrap_next = write_wrap;
    wr_en   = 1'b0;
    acc     = 1'b0;
    get_ok  = 1'b0;
    dropped = 1'b0;
    unique case (kind)
      KIND_PUT: begin
        if (!full) begin
          wr_en = 1'b1;
          acc   = 1'b1;
          {write_wrap_next, write_pos_next} = step_of(write_pos, write_wrap, capacity);
        end
      end
      KIND_FORCE: begin
        if (full) begin
          dropped = 1'b1;
          {read_wrap_next, read_pos_next} = step_of(read_pos, read_wrap, capacity);
        end
        wr_en = 1'b1;
        acc   = 1'b1;
        {write_wrap_next, write_pos_next} = step_of(write_pos, write_wrap, capacity);
      end
      KIND_GET: begin
        if (!empty) begin
          acc    = 1'b1;
          get_ok = 1'b1;
          {read_wrap_next, read_pos_next} = step_of(read_pos, read_wrap, capacity);
        end
      end
      KIND_CLEAR: begin
        read_pos_next   = '0;
        read_wrap_next  = 1'b0;
        write_pos_next  = '0;
        write_wrap_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // status after the operation
  assign fill_post = fill_of(read_pos_next, read_wrap_next, write_pos_next, write_wrap_next,
                             capacity);

  // capacity clamp on a register write
  always_comb begin
    cap_next = cfg_value;
    if (cfg_value == '0) begin
      cap_next = CNT_W'(1);
    end else if (cfg_value > CNT_W'(CAP_MAX)) begin
      cap_next = CNT_W'(CAP_MAX);
    end
  end

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CNT_W'(CAP_RST);
      read_pos   <= '0;
      write_pos  <= '0;
      read_wrap  <= 1'b0;
      write_wrap <= 1'b0;
    end else if (cfg_we) begin
      capacity   <= cap_next;
      read_pos   <= '0;
      write_pos  <= '0;
      read_wrap  <= 1'b0;
      write_wrap <= 1'b0;
    end else if (op_fire) begin
      read_pos   <= read_pos_next;
      write_pos  <= write_pos_next;
      read_wrap  <= read_wrap_next;
      write_wrap <= write_wrap_next;
    end
  end

  // status register, loaded with each operation
  always_ff @(posedge clk) begin
    if (op_fire) begin
      status.accepted         <= acc;
      status.get_ok           <= get_ok;
      status.dropped          <= dropped;
      status.data_count       <= fill_post;
      status.space_count      <= capacity - fill_post;
      status.contiguous_count <= run_of(read_pos_next, read_wrap_next, write_pos_next,
                                        write_wrap_next, capacity);
      status.read_position    <= RPOS_W'(read_pos_next);
    end
  end

  // byte store: write at the write index, read at the old read index
  brb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(CAP_MAX)
  ) u_store (
    .clk  (clk),
    .we   (op_fire && wr_en),
    .waddr(write_pos),
    .wdata(write_byte),
    .re   (op_fire),
    .raddr(read_pos),
    .rdata(rd_byte)
  );

endmodule

// ===== tb/tb_byte_ring_buffer_fifo.sv =====
// tb_byte_ring_buffer_fifo: self-checking stream testbench for the byte ring buffer fifo
`timescale 1ns / 1ps

module tb_byte_ring_buffer_fifo;
  import brb_pkg::*;

  localparam int RING_MAX    = 256;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // kinds with no operation of their own, they only report status
  localparam logic [KIND_W-1:0] KIND_SPARE5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

  typedef struct packed {
    logic              accepted;
    logic [BYTE_W-1:0] read_byte;
    logic              dropped;
    logic [CNT_W-1:0]  held;
    logic [CNT_W-1:0]  free;
    logic [CNT_W-1:0]  run;
    logic [RPOS_W-1:0] rd_index;
  } fifo_status_t;

  typedef struct {
    bit                is_cfg;
    logic [CNT_W-1:0]  cfg_val;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] wbyte;
  } fifo_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] write_byte
  logic [2:0]  s_tuser = '0;   // [2:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [0] accepted, [8:1] read_byte, [9] dropped_oldest, [18:10] data_count,
  // [27:19] space_count, [36:28] contiguous_count, [44:37] read_position
  logic [47:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  fifo_op_t     pending_ops[$];
  fifo_status_t status_due[$];
  int           mismatches = 0;
  int           cycle_n = 0;

  // beat taps from the last rising edge, read by the falling-edge drivers
  logic s_fire = 1'b0;
  logic m_fire = 1'b0;
  logic cfg_fire = 1'b0;

  byte_ring_buffer_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the ring: size, indices with their lap bits, stored bytes
  int               ring_size = RING_MAX;
  int               rd_ptr = 0;
  int               wr_ptr = 0;
  bit               rd_lap = 1'b0;
  bit               wr_lap = 1'b0;
  logic [BYTE_W-1:0] shadow [RING_MAX];

  function automatic int held_bytes();
    if (rd_lap == wr_lap && rd_ptr <= wr_ptr) return wr_ptr - rd_ptr;
    return ring_size - rd_ptr + wr_ptr;
  endfunction

  function automatic int run_to_end();
    if (rd_ptr <= wr_ptr && rd_lap == wr_lap) return wr_ptr - rd_ptr;
    return ring_size - rd_ptr;
  endfunction

  function automatic void advance_read();
    if (rd_ptr + 1 >= ring_size) begin
      rd_ptr = 0;
      rd_lap = !rd_lap;
    end else begin
      rd_ptr++;
    end
  endfunction

  function automatic void advance_write();
    if (wr_ptr + 1 >= ring_size) begin
      wr_ptr = 0;
      wr_lap = !wr_lap;
    end else begin
      wr_ptr++;
    end
  endfunction

  function automatic void empty_ring();
    rd_ptr = 0;
    wr_ptr = 0;
    rd_lap = 1'b0;
    wr_lap = 1'b0;
  endfunction

  // ring size write: zero counts as one, oversize clamps, ring empties
  function automatic void set_ring_size(logic [CNT_W-1:0] v);
    int n;
    n = v;
    if (n < 1) n = 1;
    if (n > RING_MAX) n = RING_MAX;
    ring_size = n;
    empty_ring();
  endfunction

  // apply one operation to the shadow and return the status it reports
  function automatic fifo_status_t fifo_after_op(logic [KIND_W-1:0] kind,
                                                 logic [BYTE_W-1:0] wbyte);
    fifo_status_t st;
    int held;
    st = '0;
    case (kind)
      KIND_PUT: begin
        if (ring_size - held_bytes() != 0) begin
          shadow[wr_ptr] = wbyte;
          advance_write();
          st.accepted = 1'b1;
        end
      end
      KIND_FORCE: begin
        // full ring: oldest byte goes first
        if (ring_size - held_bytes() == 0) begin
          advance_read();
          st.dropped = 1'b1;
        end
        shadow[wr_ptr] = wbyte;
        advance_write();
        st.accepted = 1'b1;
      end
      KIND_GET: begin
        if (held_bytes() != 0) begin
          st.read_byte = shadow[rd_ptr];
          advance_read();
          st.accepted = 1'b1;
        end
      end
      KIND_CLEAR: begin
        empty_ring();
      end
      default: begin
      end
    endcase
    held = held_bytes();
    st.held = CNT_W'(held);
    st.free = CNT_W'(ring_size - held);
    st.run = CNT_W'(run_to_end());
    st.rd_index = RPOS_W'(rd_ptr);
    return st;
  endfunction

  function automatic void add_op(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] wbyte);
    fifo_op_t op;
    op.is_cfg = 1'b0;
    op.cfg_val = '0;
    op.kind = kind;
    op.wbyte = wbyte;
    pending_ops.push_back(op);
  endfunction

  function automatic void add_cfg(logic [CNT_W-1:0] v);
    fifo_op_t op;
    op.is_cfg = 1'b1;
    op.cfg_val = v;
    op.kind = KIND_PEEK;
    op.wbyte = '0;
    pending_ops.push_back(op);
  endfunction

  // random run: put_pct percent puts (a quarter of them forced), rest mostly gets
  function automatic void add_random_run(int n, int put_pct);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < put_pct) begin
        add_op(($urandom_range(0, 3) == 0) ? KIND_FORCE : KIND_PUT,
               8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 85) add_op(KIND_GET, 8'($urandom_range(0, 255)));
        else if (pick < 93) add_op(KIND_PEEK, 8'($urandom_range(0, 255)));
        else if (pick < 98)
          add_op(KIND_W'($urandom_range(KIND_SPARE5, KIND_SPARE7)),
                 8'($urandom_range(0, 255)));
        else add_op(KIND_CLEAR, 8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // beat taps and run limit
  always @(posedge clk) begin
    s_fire <= s_tvalid && s_tready;
    m_fire <= m_tvalid && m_tready;
    cfg_fire <= cfg_valid && cfg_ready;
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // monitor: predict on input beats, check output beats against the oldest
  always @(posedge clk) begin : monitor
    fifo_status_t got;
    fifo_status_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) set_ring_size(cfg_data);
      if (s_tvalid && s_tready) status_due.push_back(fifo_after_op(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got.accepted = m_tdata[0];
        got.read_byte = m_tdata[8:1];
        got.dropped = m_tdata[9];
        got.held = m_tdata[18:10];
        got.free = m_tdata[27:19];
        got.run = m_tdata[36:28];
        got.rd_index = m_tdata[44:37];
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result beat with nothing expected: %h", $time, m_tdata);
        end else begin
          want = status_due.pop_front();
          if (got.accepted !== want.accepted || got.read_byte !== want.read_byte ||
              got.dropped !== want.dropped || got.held !== want.held ||
              got.free !== want.free || got.run !== want.run ||
              got.rd_index !== want.rd_index) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $write("[%0t] mismatch acc/byte/drop/data/space/run/rpos ", $time);
              $display("exp %0d/%0d/%0d/%0d/%0d/%0d/%0d act %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                       want.accepted, want.read_byte, want.dropped, want.held,
                       want.free, want.run, want.rd_index, got.accepted, got.read_byte,
                       got.dropped, got.held, got.free, got.run, got.rd_index);
            end
          end
        end
      end
    end
  end

  // input driver: random gaps, bursts without gaps, ring size writes only when idle
  int       gap_left = 0;
  int       settle = 0;
  int       sent_n = 0;
  logic     next_valid;
  logic     next_cfg;
  fifo_op_t head_op;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      next_valid = s_tvalid && !s_fire;
      next_cfg = cfg_valid && !cfg_fire;
      settle = (status_due.size() == 0) ? settle + 1 : 0;
      if (s_fire) begin
        sent_n++;
        gap_left = (sent_n % 96 < 24) ? 0 : $urandom_range(0, 7);
      end else if (gap_left > 0 && !next_valid && !next_cfg) begin
        gap_left--;
      end
      if (!next_valid && !next_cfg && gap_left == 0 && pending_ops.size() > 0) begin
        if (!pending_ops[0].is_cfg) begin
          head_op = pending_ops.pop_front();
          s_tuser <= head_op.kind;
          s_tdata <= head_op.wbyte;
          next_valid = 1'b1;
        end else if (settle >= 4) begin
          head_op = pending_ops.pop_front();
          cfg_data <= head_op.cfg_val;
          next_cfg = 1'b1;
        end
      end
      s_tvalid <= next_valid;
      cfg_valid <= next_cfg;
    end
  end

  // long receiver hold-off once, so the block backs up and stalls its input
  int hold_left = 0;
  int taken_n = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (s_fire) taken_n <= taken_n + 1;
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && taken_n >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // output receiver: random stall after each beat, with stall-free stretches
  int rx_wait = 0;
  int rx_beats = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_fire) begin
        rx_beats++;
        rx_wait = (rx_beats % 80 < 20) ? 0 : $urandom_range(0, 7);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  initial begin
    // directed: empty ring, byte extremes, tiny rings running full, spare kinds
    add_op(KIND_PEEK, 8'h00);
    add_op(KIND_GET, 8'h00);
    add_op(KIND_PUT, 8'h00);
    add_op(KIND_PUT, 8'hFF);
    add_op(KIND_GET, 8'h00);
    add_op(KIND_GET, 8'h00);
    add_op(KIND_GET, 8'hFF);
    add_cfg(9'd2);
    add_op(KIND_PUT, 8'hA5);
    add_op(KIND_PUT, 8'h5A);
    add_op(KIND_PUT, 8'h33);
    add_op(KIND_FORCE, 8'h77);
    add_op(KIND_GET, 8'h00);
    add_op(KIND_GET, 8'h00);
    add_op(KIND_GET, 8'h00);
    add_op(KIND_SPARE5, 8'hFF);
    add_op(KIND_SPARE6, 8'hFF);
    add_op(KIND_SPARE7, 8'hFF);
    add_op(KIND_PUT, 8'h12);
    add_op(KIND_CLEAR, 8'h00);
    add_op(KIND_GET, 8'h00);
    add_cfg(9'd0);
    add_op(KIND_PUT, 8'h11);
    add_op(KIND_PUT, 8'h22);
    add_op(KIND_FORCE, 8'h44);
    add_op(KIND_GET, 8'h00);

    // random phases over several ring sizes, a fill and drain wave on a large ring
    add_cfg(9'd511);
    add_random_run(120, 50);
    add_cfg(9'($urandom_range(130, 200)));
    add_random_run(200, 88);
    add_random_run(120, 20);
    add_cfg(9'd1);
    add_random_run(60, 50);
    add_cfg(9'd3);
    add_random_run(80, 55);
    add_cfg(9'($urandom_range(257, 510)));
    add_random_run(60, 60);
    add_cfg(9'd256);
    add_random_run(60, 50);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_ops.size() > 0 || s_tvalid || cfg_valid || status_due.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
